/* rtl/otsu_pkg.sv */
// Package for the Otsu frame threshold block: payload structs, state and
// operation codes, command/status bundles and width constants.
// No dependencies.
`timescale 1ns / 1ps

package otsu_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int GRAY_LEVELS    = 256;
  localparam int LEVEL_BITS     = 8;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIXED_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USE_OTSU        = 8'd1;

  localparam logic [LEVEL_BITS-1:0] FIXED_THRESHOLD_RST = 8'd128;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN_OUT       = 8'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX_OUT       = 8'd254;
  localparam logic [LEVEL_BITS-1:0] LEVEL_BLACK         = 8'd0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_WHITE         = 8'd255;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] gray_pixel;
    logic                  frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] threshold_level;
    logic                  used_fallback;
  } thr_out_t;

  typedef enum logic [2:0] {
    MUL_A,
    MUL_B,
    MUL_DEN,
    MUL_SQ,
    MUL_L,
    MUL_R
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_RUN,
    ST_DRAIN,
    ST_RD,
    ST_ACC,
    ST_SA,
    ST_MA,
    ST_MB,
    ST_MDEN,
    ST_MSQ,
    ST_DEC,
    ST_ML,
    ST_MR,
    ST_NEXT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic    pix_en;
    logic    clr_wr;
    logic    sw_rd;
    logic    sweep_init;
    logic    lv_inc;
    logic    acc;
    logic    set_stop;
    logic    mul_start;
    mul_op_t mul_op;
    logic    mul_latch;
    logic    take_best;
    logic    cmp_upd;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    logic lv_last;
    logic stopped;
    logic nb_zero;
    logic nb_full;
    logic mul_done;
    logic best_valid;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/otsu_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle, finishing early
// once the remaining multiplier bits are zero. Uses no package items.
`timescale 1ns / 1ps

module otsu_mul #(
  parameter int PW = 160,
  parameter int MW = 56
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] mcand_in,
  input  logic [MW-1:0] mplier_in,
  output logic [PW-1:0] product,
  output logic          done
);

  logic [PW-1:0] mcand;
  logic [MW-1:0] mplier;
  logic [PW-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (start) begin
      mplier <= mplier_in;
    end else if (mplier != '0) begin
      mplier <= mplier >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= mcand_in;
      acc   <= '0;
    end else if (mplier != '0) begin
      mcand <= mcand << 1;
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
    end
  end

  assign product = acc;
  assign done    = (mplier == '0);

endmodule

/* rtl/otsu_dp.sv */
// Datapath: histogram memory with pixel update path, frame totals, sweep
// accumulators, best-candidate registers, configuration and output register.
// Depends on otsu_pkg and otsu_mul.
`timescale 1ns / 1ps

module otsu_dp #(
  parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  otsu_pkg::cmd_t                       cmd,
  output otsu_pkg::sts_t                       sts,
  input  logic                                 in_valid,
  input  otsu_pkg::pix_in_t                    in_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output otsu_pkg::thr_out_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [otsu_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [otsu_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int LB   = otsu_pkg::LEVEL_BITS;
  localparam int C    = COUNT_BITS;
  localparam int SW   = C + LB;
  localparam int AW   = 2 * C + LB;
  localparam int DENW = 2 * C;
  localparam int SQW  = 2 * AW;
  localparam int PW   = SQW + DENW;
  localparam logic [C-1:0] COUNT_MAX = {C{1'b1}};

  logic [C-1:0] hist [otsu_pkg::GRAY_LEVELS];
  logic [C-1:0] rdata;

  logic [C-1:0]  n_all;
  logic [SW-1:0] t_all;
  logic          p_valid;
  logic [LB-1:0] p_addr;
  logic          fwd_hit;
  logic [C-1:0]  fwd_val;
  logic [C-1:0]  pix_cnt;
  logic          pix_acc;

  logic [LB-1:0] lv;
  logic [C-1:0]  n_b;
  logic [SW-1:0] s_b;
  logic          stopped;
  logic [AW-1:0] a_reg;
  logic [AW-1:0] d_reg;
  logic [DENW-1:0] den;
  logic [SQW-1:0]  sq;
  logic [PW-1:0]   lhs;
  logic [SQW-1:0]  best_sq;
  logic [DENW-1:0] best_den;
  logic [LB-1:0]   best_lv;
  logic            best_valid;
  otsu_pkg::mul_op_t cur_op;

  logic [LB-1:0] fixed_threshold;
  logic          use_otsu;

  logic [C-1:0]  nb_new;
  logic [SW-1:0] sb_new;
  logic [C-1:0]  n_f;
  logic [PW-1:0] mcand;
  logic [AW-1:0] mplier;
  logic [PW-1:0] product;
  logic          mul_done;
  logic [AW-1:0] prod_a;
  logic [LB-1:0] fb_level;
  logic          otsu_ok;

  logic          mem_we;
  logic [LB-1:0] mem_waddr;
  logic [C-1:0]  mem_wdata;
  logic [LB-1:0] mem_raddr;

  // Pixel path: read at acceptance, increment and write in the next cycle.
  assign pix_acc = cmd.pix_en && in_valid && (n_all < COUNT_MAX);
  assign pix_cnt = fwd_hit ? fwd_val : rdata;

  always_comb begin
    mem_raddr = cmd.sw_rd ? lv : in_data.gray_pixel;
    mem_we    = 1'b0;
    mem_waddr = lv;
    mem_wdata = '0;
    if (p_valid) begin
      mem_we    = 1'b1;
      mem_waddr = p_addr;
      mem_wdata = pix_cnt + C'(1);
    end else if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    rdata <= hist[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    p_addr  <= in_data.gray_pixel;
    fwd_hit <= p_valid && (p_addr == in_data.gray_pixel);
    fwd_val <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.fin) begin
      n_all <= '0;
      t_all <= '0;
    end else if (pix_acc) begin
      n_all <= n_all + C'(1);
      t_all <= t_all + SW'(in_data.gray_pixel);
    end
  end

  // Sweep accumulators.
  assign nb_new = n_b + rdata;
  assign sb_new = s_b + SW'(lv) * SW'(rdata);
  assign n_f    = n_all - n_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv         <= '0;
      stopped    <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (cmd.sweep_init) begin
        lv         <= '0;
        stopped    <= !use_otsu;
        best_valid <= 1'b0;
      end else begin
        if (cmd.lv_inc) begin
          lv <= lv + LB'(1);
        end
        if (cmd.set_stop) begin
          stopped <= 1'b1;
        end
        if (cmd.take_best) begin
          best_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      n_b <= '0;
      s_b <= '0;
    end else if (cmd.acc) begin
      n_b <= nb_new;
      s_b <= sb_new;
    end
    if (cmd.take_best || (cmd.cmp_upd && (lhs > product))) begin
      best_sq  <= sq;
      best_den <= den;
      best_lv  <= lv;
    end
  end

  // Shared multiplier operand selection and result steering.
  always_comb begin
    unique case (cmd.mul_op)
      otsu_pkg::MUL_A: begin
        mcand  = PW'(n_all);
        mplier = AW'(s_b);
      end
      otsu_pkg::MUL_B: begin
        mcand  = PW'(t_all);
        mplier = AW'(n_b);
      end
      otsu_pkg::MUL_DEN: begin
        mcand  = PW'(n_b);
        mplier = AW'(n_f);
      end
      otsu_pkg::MUL_SQ: begin
        mcand  = PW'(d_reg);
        mplier = d_reg;
      end
      otsu_pkg::MUL_L: begin
        mcand  = PW'(sq);
        mplier = AW'(best_den);
      end
      otsu_pkg::MUL_R: begin
        mcand  = PW'(best_sq);
        mplier = AW'(den);
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  otsu_mul #(
    .PW(PW),
    .MW(AW)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mul_start),
    .mcand_in (mcand),
    .mplier_in(mplier),
    .product  (product),
    .done     (mul_done)
  );

  assign prod_a = product[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      cur_op <= cmd.mul_op;
    end
    if (cmd.mul_latch) begin
      unique case (cur_op)
        otsu_pkg::MUL_A:   a_reg <= prod_a;
        otsu_pkg::MUL_B:   d_reg <= (a_reg >= prod_a) ? (a_reg - prod_a) : (prod_a - a_reg);
        otsu_pkg::MUL_DEN: den   <= product[DENW-1:0];
        otsu_pkg::MUL_SQ:  sq    <= product[SQW-1:0];
        otsu_pkg::MUL_L:   lhs   <= product;
        otsu_pkg::MUL_R:   lhs   <= lhs;
        default:           lhs   <= lhs;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_threshold <= otsu_pkg::FIXED_THRESHOLD_RST;
      use_otsu        <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == otsu_pkg::REG_FIXED_THRESHOLD) begin
        fixed_threshold <= cfg_data[LB-1:0];
      end else if (cfg_index == otsu_pkg::REG_USE_OTSU) begin
        use_otsu <= cfg_data[0];
      end
    end
  end

  // Result register.
  always_comb begin
    if (fixed_threshold < otsu_pkg::LEVEL_MIN_OUT) begin
      fb_level = otsu_pkg::LEVEL_MIN_OUT;
    end else if (fixed_threshold > otsu_pkg::LEVEL_MAX_OUT) begin
      fb_level = otsu_pkg::LEVEL_MAX_OUT;
    end else begin
      fb_level = fixed_threshold;
    end
  end

  assign otsu_ok = best_valid && (best_lv != otsu_pkg::LEVEL_BLACK)
                   && (best_lv != otsu_pkg::LEVEL_WHITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data.threshold_level <= otsu_ok ? best_lv : fb_level;
      out_data.used_fallback   <= !otsu_ok;
    end
  end

  assign sts.lv_last    = (lv == otsu_pkg::LEVEL_WHITE);
  assign sts.stopped    = stopped;
  assign sts.nb_zero    = (nb_new == '0);
  assign sts.nb_full    = (nb_new >= n_all);
  assign sts.mul_done   = mul_done;
  assign sts.best_valid = best_valid;
  assign sts.out_busy   = out_valid && !out_ready;

endmodule

/* rtl/otsu_ctrl.sv */
// Controller state machine: pixel intake, histogram sweep sequencing,
// multiplier scheduling and result hand-off. Depends on otsu_pkg.
`timescale 1ns / 1ps

module otsu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              frame_end,
  output logic              in_ready,
  input  otsu_pkg::sts_t    sts,
  output otsu_pkg::cmd_t    cmd
);

  otsu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= otsu_pkg::ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = otsu_pkg::MUL_A;
    in_ready   = 1'b0;
    unique case (state)
      otsu_pkg::ST_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.lv_inc = 1'b1;
        if (sts.lv_last) begin
          state_next = otsu_pkg::ST_RUN;
        end
      end
      otsu_pkg::ST_RUN: begin
        in_ready   = 1'b1;
        cmd.pix_en = 1'b1;
        if (in_valid && frame_end) begin
          state_next = otsu_pkg::ST_DRAIN;
        end
      end
      otsu_pkg::ST_DRAIN: begin
        cmd.sweep_init = 1'b1;
        state_next     = otsu_pkg::ST_RD;
      end
      otsu_pkg::ST_RD: begin
        cmd.sw_rd  = 1'b1;
        cmd.clr_wr = 1'b1;
        state_next = otsu_pkg::ST_ACC;
      end
      otsu_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        priority if (sts.stopped || sts.nb_zero) begin
          state_next = otsu_pkg::ST_NEXT;
        end else if (sts.nb_full) begin
          cmd.set_stop = 1'b1;
          state_next   = otsu_pkg::ST_NEXT;
        end else begin
          state_next = otsu_pkg::ST_SA;
        end
      end
      otsu_pkg::ST_SA: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = otsu_pkg::MUL_A;
        state_next    = otsu_pkg::ST_MA;
      end
      otsu_pkg::ST_MA: begin
        if (sts.mul_done) begin
          cmd.mul_latch = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_op    = otsu_pkg::MUL_B;
          state_next    = otsu_pkg::ST_MB;
        end
      end
      otsu_pkg::ST_MB: begin
        if (sts.mul_done) begin
          cmd.mul_latch = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_op    = otsu_pkg::MUL_DEN;
          state_next    = otsu_pkg::ST_MDEN;
        end
      end
      otsu_pkg::ST_MDEN: begin
        if (sts.mul_done) begin
          cmd.mul_latch = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_op    = otsu_pkg::MUL_SQ;
          state_next    = otsu_pkg::ST_MSQ;
        end
      end
      otsu_pkg::ST_MSQ: begin
        if (sts.mul_done) begin
          cmd.mul_latch = 1'b1;
          state_next    = otsu_pkg::ST_DEC;
        end
      end
      otsu_pkg::ST_DEC: begin
        if (!sts.best_valid) begin
          cmd.take_best = 1'b1;
          state_next    = otsu_pkg::ST_NEXT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = otsu_pkg::MUL_L;
          state_next    = otsu_pkg::ST_ML;
        end
      end
      otsu_pkg::ST_ML: begin
        if (sts.mul_done) begin
          cmd.mul_latch = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_op    = otsu_pkg::MUL_R;
          state_next    = otsu_pkg::ST_MR;
        end
      end
      otsu_pkg::ST_MR: begin
        if (sts.mul_done) begin
          cmd.cmp_upd = 1'b1;
          state_next  = otsu_pkg::ST_NEXT;
        end
      end
      otsu_pkg::ST_NEXT: begin
        if (sts.lv_last) begin
          state_next = otsu_pkg::ST_FIN;
        end else begin
          cmd.lv_inc = 1'b1;
          state_next = otsu_pkg::ST_RD;
        end
      end
      otsu_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = otsu_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = otsu_pkg::ST_CLR;
      end
    endcase
  end

endmodule

/* rtl/otsu_frame_threshold_top.sv */
// Top level of the Otsu frame threshold block: joins controller and datapath.
// Depends on otsu_pkg, otsu_ctrl, otsu_dp and otsu_mul.
`timescale 1ns / 1ps

// Gray pixels are taken one per clock on the input channel, outside the
// clearing pass and the sweeps, and counted into a 256-bin histogram held
// in a single-port-write memory. The transfer marked frame_end starts a
// sweep over all 256 levels, during which no pixel is accepted. Each level
// that splits the frame runs up to six products through one shared
// shift-and-add multiplier, each finishing once the significant bits of its
// multiplier operand are used up (COUNT_BITS+8 bits for the partial level
// sum, COUNT_BITS for each of the two pixel counts, 2*COUNT_BITS+8 for the
// difference and 2*COUNT_BITS for each of the two class-size products), so
// the multiplier dominates the sweep time. The same sweep clears the
// histogram for the next frame. After reset a clearing pass over all 256
// bins runs before the first pixel is accepted; configuration writes are
// taken at any time. One result transfer follows each frame; the result
// register lets the next frame stream in while it waits, and a new result
// is held back only until the previous one has gone.

module otsu_frame_threshold_top #(
  parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  otsu_pkg::pix_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output otsu_pkg::thr_out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [otsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [otsu_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // Commands flow from the controller to the datapath, status flows back.
  otsu_pkg::cmd_t cmd;
  otsu_pkg::sts_t sts;

  otsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .frame_end(in_data.frame_end),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  otsu_dp #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_valid (in_valid),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

/* test/otsu_result_checker.sv */
// Checker for the Otsu frame threshold block: watches the pixel, result and
// configuration ports, predicts each frame's threshold and compares it.
// Depends on otsu_pkg.
`timescale 1ns / 1ps

module otsu_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  otsu_pkg::pix_in_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  otsu_pkg::thr_out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [otsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [otsu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  localparam logic [15:0] PIXEL_COUNT_MAX = 16'hFFFF;

  logic [15:0]        bin_count [otsu_pkg::GRAY_LEVELS];
  logic [15:0]        pixel_count;
  logic [23:0]        level_sum;
  logic [7:0]         fallback_reg;
  logic               otsu_enable;
  otsu_pkg::thr_out_t expected_thresholds [$];

  assign pending = expected_thresholds.size();

  // Sweeps the histogram and keeps the first level with the strictly largest
  // between-class variance, compared by exact cross-multiplication.
  function automatic otsu_pkg::thr_out_t predict_threshold();
    logic [63:0]        n_all, t_all, n_b, s_b, n_f, a, b, d, den, best_d, best_den;
    logic [127:0]       lhs, rhs;
    logic [7:0]         fallback;
    int                 best;
    otsu_pkg::thr_out_t res;
    n_all = pixel_count;
    t_all = level_sum;
    n_b = 0;
    s_b = 0;
    best_d = 0;
    best_den = 0;
    best = -1;
    fallback = fallback_reg;
    if (fallback < otsu_pkg::LEVEL_MIN_OUT) fallback = otsu_pkg::LEVEL_MIN_OUT;
    if (fallback > otsu_pkg::LEVEL_MAX_OUT) fallback = otsu_pkg::LEVEL_MAX_OUT;
    if (otsu_enable) begin
      for (int lv = 0; lv < otsu_pkg::GRAY_LEVELS; lv++) begin
        n_b = n_b + bin_count[lv];
        if (n_b == 0) continue;
        if (n_b >= n_all) break;
        n_f = n_all - n_b;
        s_b = s_b + lv * bin_count[lv];
        a = n_all * s_b;
        b = t_all * n_b;
        d = (a >= b) ? a - b : b - a;
        den = n_b * n_f;
        if (best < 0) begin
          best = lv;
          best_d = d;
          best_den = den;
        end else begin
          lhs = 128'(d) * 128'(d) * 128'(best_den);
          rhs = 128'(best_d) * 128'(best_d) * 128'(den);
          if (lhs > rhs) begin
            best = lv;
            best_d = d;
            best_den = den;
          end
        end
      end
    end
    if (best <= 0 || best >= 255) begin
      res.threshold_level = fallback;
      res.used_fallback = 1'b1;
    end else begin
      res.threshold_level = best[7:0];
      res.used_fallback = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    otsu_pkg::thr_out_t want;
    if (rst) begin
      fallback_reg <= otsu_pkg::FIXED_THRESHOLD_RST;
      otsu_enable <= 1'b1;
      pixel_count = '0;
      level_sum = '0;
      for (int i = 0; i < otsu_pkg::GRAY_LEVELS; i++) bin_count[i] = '0;
      expected_thresholds.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == otsu_pkg::REG_FIXED_THRESHOLD) fallback_reg <= cfg_data;
        else if (cfg_index == otsu_pkg::REG_USE_OTSU) otsu_enable <= cfg_data[0];
      end
      if (in_valid && in_ready) begin
        if (pixel_count < PIXEL_COUNT_MAX) begin
          bin_count[in_data.gray_pixel] = bin_count[in_data.gray_pixel] + 1'b1;
          pixel_count = pixel_count + 1'b1;
          level_sum = level_sum + in_data.gray_pixel;
        end
        if (in_data.frame_end) begin
          expected_thresholds.push_back(predict_threshold());
          for (int i = 0; i < otsu_pkg::GRAY_LEVELS; i++) bin_count[i] = '0;
          pixel_count = '0;
          level_sum = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_thresholds.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result transfer with nothing expected: level %0d fallback %0b",
                     $realtime, out_data.threshold_level, out_data.used_fallback);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_thresholds.pop_front();
          if (out_data.threshold_level !== want.threshold_level ||
              out_data.used_fallback !== want.used_fallback) begin
            if (fail_count < 10)
              $display({"%0t: mismatch: expected level %0d fallback %0b, ",
                        "got level %0d fallback %0b"},
                       $realtime, want.threshold_level, want.used_fallback,
                       out_data.threshold_level, out_data.used_fallback);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the Otsu frame threshold block: clock, reset, pixel and
// configuration stimulus, result-side back-pressure and the final verdict.
// Depends on otsu_pkg, otsu_frame_threshold_top and otsu_result_checker.
`timescale 1ns / 1ps

module tb_top;

  // An index that maps to no register.
  localparam logic [otsu_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 8'd5;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  otsu_pkg::pix_in_t                   in_data;
  logic                                out_valid;
  logic                                out_ready;
  otsu_pkg::thr_out_t                  out_data;
  logic                                cfg_we;
  logic [otsu_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [otsu_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  int                                  fail_count;
  int                                  pending;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct;
  int stall_pct;
  // Set by the stimulus to ask the receiver process for one long hold-off.
  logic hold_request;

  otsu_frame_threshold_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  otsu_result_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // There are well under a hundred frames, so even with the worst sweep in
  // every frame this bound is many times the slowest correct run, long
  // receiver stalls included.
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: ready is redrawn at every falling edge. A hold-off request
  // keeps ready low once for a long count of cycles so that a result waits in
  // the output register, the next sweep cannot finish and pixel input stalls.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_left = 3000;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Drives one pixel and returns at the falling edge after its transfer.
  // Valid only drops for a gap, so back-to-back pixels keep it high.
  task automatic send_pixel(input logic [7:0] level, input logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.gray_pixel = level;
    in_data.frame_end = last;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Sends one frame whose levels follow a random shape: uniform noise, two
  // clusters, a single level, only black and white, or a few fixed levels.
  task automatic send_frame(input int len);
    int          shape;
    logic [7:0]  c1, c2, c3, level;
    shape = $urandom_range(4);
    c1 = $urandom_range(247);
    c2 = $urandom_range(247);
    c3 = $urandom;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: level = $urandom;
        1: level = ($urandom_range(1) ? c1 : c2) + $urandom_range(8);
        2: level = c1;
        3: level = $urandom_range(1) ? otsu_pkg::LEVEL_WHITE : otsu_pkg::LEVEL_BLACK;
        default: begin
          case ($urandom_range(2))
            0: level = c1;
            1: level = c2;
            default: level = c3;
          endcase
        end
      endcase
      send_pixel(level, i == len - 1);
    end
  endtask

  // Registers are only written once every expected result has been
  // transferred; the short pause covers the block leaving its last sweep.
  task automatic write_reg(input logic [otsu_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [otsu_pkg::CFG_DATA_BITS-1:0] value);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_list(input logic [7:0] levels [$]);
    for (int i = 0; i < levels.size(); i++)
      send_pixel(levels[i], i == levels.size() - 1);
  endtask

  task automatic random_phase(input int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 20);
      send_frame(len);
      sent += len;
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames with reset settings: a lone pixel, black and white
    // only, a split right below white, a split at black, a clean two-level
    // frame and a frame of one level.
    send_list('{8'd0});
    send_list('{8'd0, 8'd255});
    send_list('{8'd254, 8'd255});
    send_list('{8'd0, 8'd1});
    send_list('{8'd10, 8'd10, 8'd200, 8'd200});
    send_list('{8'd5, 8'd5, 8'd5});
    // The fallback is clamped at both ends of its range.
    write_reg(otsu_pkg::REG_FIXED_THRESHOLD, 8'd0);
    send_list('{8'd0, 8'd255});
    write_reg(otsu_pkg::REG_FIXED_THRESHOLD, 8'd255);
    send_list('{8'd7});
    // Only bit 0 of the enable counts, and an unknown index changes nothing.
    write_reg(otsu_pkg::REG_USE_OTSU, 8'd2);
    write_reg(REG_UNMAPPED, 8'd1);
    send_list('{8'd10, 8'd200});

    // Phase one: no idling, Otsu on, lowest fallback.
    write_reg(otsu_pkg::REG_USE_OTSU, 8'd1);
    write_reg(otsu_pkg::REG_FIXED_THRESHOLD, 8'd1);
    random_phase(250);

    // Phase two: sender idle most of the time, highest fallback. A long
    // receiver hold-off lands while frames keep arriving.
    write_reg(otsu_pkg::REG_FIXED_THRESHOLD, 8'd254);
    idle_pct = 74;
    hold_request = 1'b1;
    random_phase(250);
    hold_request = 1'b0;

    // Phase three: receiver stalling, Otsu off.
    write_reg(otsu_pkg::REG_USE_OTSU, 8'd0);
    write_reg(otsu_pkg::REG_FIXED_THRESHOLD, 8'd77);
    idle_pct = 0;
    stall_pct = 74;
    random_phase(250);

    // Phase four: both sides idle, Otsu back on with a mid fallback.
    write_reg(otsu_pkg::REG_USE_OTSU, 8'd1);
    write_reg(otsu_pkg::REG_FIXED_THRESHOLD, 8'd128);
    idle_pct = 28;
    stall_pct = 28;
    random_phase(250);

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
